// ----- rtl/fractal_value_noise_cell_test_assert.svh -----
// Assertion macros shared by the noise block.
`ifndef FRACTAL_VALUE_NOISE_CELL_TEST_ASSERT_SVH
`define FRACTAL_VALUE_NOISE_CELL_TEST_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define FVN_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define FVN_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/fvn_pkg.sv -----
// ----------------------------------------------------------------------------
// fvn_pkg
// Types, constants and arithmetic helpers of the fractal value noise block.
// ----------------------------------------------------------------------------
package fvn_pkg;

    localparam int OCTAVES = 3;
    // Stages per octave cell.
    localparam int CELL_STAGES = 8;
    localparam int LATENCY = OCTAVES * CELL_STAGES + 2;

    localparam logic [1:0] REG_SEED        = 2'd0;
    localparam logic [1:0] REG_NOISE_SCALE = 2'd1;
    localparam logic [1:0] REG_DENSITY     = 2'd2;
    localparam logic [1:0] REG_EASED_MODE  = 2'd3;

    // Hash offsets of the corners (x0,y0), (x0+1,y0), (x0,y0+1), (x0+1,y0+1).
    // The linear hash term moves by 1619 per column and 31337 per row.
    localparam logic [31:0] HASH_OFS [4] = '{32'd0, 32'd1619, 32'd31337, 32'd32956};

    // Word handed from one octave cell to the next.
    typedef struct packed {
        logic               vld;
        logic signed [40:0] cx;
        logic signed [40:0] cy;
        logic signed [19:0] sum;
    } fvn_link_t;

    // Rounded Q16 product of two signed values.
    function automatic logic signed [19:0] mul_q16(
        input logic signed [19:0] a,
        input logic signed [19:0] b
    );
        logic signed [39:0] p;
        p = a * b + 40'sd32768;
        return p[35:16];
    endfunction

    // Rounded Q16 product with headroom for the ease polynomial.
    function automatic logic signed [23:0] mul_q16w(
        input logic signed [23:0] a,
        input logic signed [23:0] b
    );
        logic signed [47:0] p;
        p = a * b + 48'sd32768;
        return p[39:16];
    endfunction

    // Linear part of the corner hash, before the mask.
    function automatic logic [31:0] hash_lin(
        input logic [31:0] x,
        input logic [31:0] y,
        input logic [31:0] s
    );
        return 32'd1619 * x + 32'd31337 * y + 32'd1013 * s;
    endfunction

    // Mask to 31 bits and fold the upper bits down.
    function automatic logic [31:0] hash_fold(input logic [31:0] lin);
        logic [31:0] n;
        n = lin & 32'h7fffffff;
        return (n >> 13) ^ n;
    endfunction

    // Corner value in Q4.16 from the mixed hash word.
    function automatic logic signed [19:0] hash_value(input logic [31:0] m);
        return 20'sd65536 - $signed({3'b000, m[30:14]});
    endfunction

endpackage

// ----- rtl/fvn_octave_cell.sv -----
// ----------------------------------------------------------------------------
// fvn_octave_cell
// One octave of value noise: hash, ease, blend, weight, add to running sum.
// ----------------------------------------------------------------------------
module fvn_octave_cell
    import fvn_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [2:0]        octave,
    input  logic [31:0]       seed,
    input  logic              eased,
    input  fvn_link_t         link_in,
    output fvn_link_t         link_out
);

    // Control and payload of every stage.
    logic [CELL_STAGES-1:0] vld_reg;
    logic signed [40:0] cx_reg [CELL_STAGES];
    logic signed [40:0] cy_reg [CELL_STAGES];
    logic signed [19:0] sum_reg [CELL_STAGES-1];
    logic signed [19:0] sum_out_reg;
    logic [31:0] oct_seed;
    logic [31:0] hash_base;
    // Hash pipeline, one lane per corner.
    logic [31:0] hn_reg [4];
    logic [31:0] hsq_reg [4];
    logic [31:0] hn2_reg [4];
    logic [31:0] hmix_reg [4];
    logic [31:0] hn3_reg [4];
    logic signed [19:0] corner_reg [4];
    // Ease pipeline, lane 0 for x and lane 1 for y.
    logic signed [23:0] frac_reg [2];
    logic signed [23:0] sq_reg [2];
    logic signed [23:0] inner_reg [2];
    logic signed [23:0] frac2_reg [2];
    logic signed [23:0] cube_reg [2];
    logic signed [23:0] inner3_reg [2];
    logic signed [23:0] frac3_reg [2];
    logic signed [23:0] ease_raw [2];
    logic signed [19:0] eased_t [2];
    logic signed [19:0] t_reg [2];
    logic signed [19:0] ty5_reg;
    logic signed [19:0] u_reg, v_reg, o_reg, w_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[CELL_STAGES-2:0], link_in.vld};
        end
    end

    // Coordinates and sums ride alongside the arithmetic.
    always_ff @(posedge aclk) begin
        cx_reg[0] <= link_in.cx;
        cy_reg[0] <= link_in.cy;
        sum_reg[0] <= link_in.sum;
        for (int i = 1; i < CELL_STAGES; i++) begin
            cx_reg[i] <= cx_reg[i-1];
            cy_reg[i] <= cy_reg[i-1];
        end
        for (int i = 1; i < CELL_STAGES - 1; i++) begin
            sum_reg[i] <= sum_reg[i-1];
        end
    end

    // Floor corner of the sample point and the octave seed.
    assign oct_seed  = seed + 32'(octave);
    assign hash_base = hash_lin(32'(link_in.cx >>> 16), 32'(link_in.cy >>> 16), oct_seed);

    // Corner hash over stages one to four.
    always_ff @(posedge aclk) begin
        for (int c = 0; c < 4; c++) begin
            hn_reg[c]     <= hash_fold(hash_base + HASH_OFS[c]);
            hsq_reg[c]    <= hn_reg[c] * hn_reg[c];
            hn2_reg[c]    <= hn_reg[c];
            hmix_reg[c]   <= hsq_reg[c] * 32'd60493 + 32'd19990303;
            hn3_reg[c]    <= hn2_reg[c];
            corner_reg[c] <= hash_value(hn3_reg[c] * hmix_reg[c] + 32'd1376312589);
        end
    end

    // Ease curve of both fractions, or the plain fractions when eased is low, over stages one to four.
    always_ff @(posedge aclk) begin
        frac_reg[0] <= $signed({8'd0, link_in.cx[15:0]});
        frac_reg[1] <= $signed({8'd0, link_in.cy[15:0]});
        for (int a = 0; a < 2; a++) begin
            sq_reg[a]     <= mul_q16w(frac_reg[a], frac_reg[a]);
            inner_reg[a]  <= mul_q16w(frac_reg[a], 24'(6 * frac_reg[a]) - 24'sd983040)
                           + 24'sd655360;
            frac2_reg[a]  <= frac_reg[a];
            cube_reg[a]   <= mul_q16w(sq_reg[a], frac2_reg[a]);
            inner3_reg[a] <= inner_reg[a];
            frac3_reg[a]  <= frac2_reg[a];
            t_reg[a]      <= eased ? eased_t[a] : 20'(frac3_reg[a]);
        end
    end

    // Final ease product, clamped to the unit range.
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            ease_raw[a] = mul_q16w(cube_reg[a], inner3_reg[a]);
            eased_t[a]  = (ease_raw[a] < 0) ? 20'sd0
                        : (ease_raw[a] > 24'sd65536) ? 20'sd65536 : 20'(ease_raw[a]);
        end
    end

    // Blend along x, then y, then weight the octave and add it to the sum.
    always_ff @(posedge aclk) begin
        u_reg   <= corner_reg[0] + mul_q16(corner_reg[1] - corner_reg[0], t_reg[0]);
        v_reg   <= corner_reg[2] + mul_q16(corner_reg[3] - corner_reg[2], t_reg[0]);
        ty5_reg <= t_reg[1];
        o_reg   <= u_reg + mul_q16(v_reg - u_reg, ty5_reg);
        w_reg   <= (octave == 3'd0) ? o_reg
                 : (o_reg + (20'sd1 <<< (octave - 3'd1))) >>> octave;
        sum_out_reg <= sum_reg[CELL_STAGES-2] + w_reg;
    end

    assign link_out.vld = vld_reg[CELL_STAGES-1];
    assign link_out.cx  = cx_reg[CELL_STAGES-1] <<< 1;
    assign link_out.cy  = cy_reg[CELL_STAGES-1] <<< 1;
    assign link_out.sum = sum_out_reg;

endmodule

// ----- rtl/fractal_value_noise_cell_test.sv -----
// ----------------------------------------------------------------------------
// fractal_value_noise_cell_test
// Fractal 2D value noise cell test with a density threshold.
// ----------------------------------------------------------------------------
// One cell word is taken every cycle while s_tready is high; its result word
// passes the input register, the chain of per-octave cells of eight stages
// each and the output queue before it can be taken.
// The chain always advances; results wait in a small queue while the receiver
// stalls, and the input is held off once OCTAVES*8+3 words are in flight or queued.
module fractal_value_noise_cell_test
    import fvn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // cell_x [15:0], cell_y [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // filled [0], noise_sum [18:1]
);
`include "fractal_value_noise_cell_test_assert.svh"

    localparam int QD = LATENCY + 2;
    localparam int QW = $clog2(QD);

    logic [31:0] seed_reg;
    logic [15:0] scale_reg;
    logic [16:0] density_reg;
    logic        eased_reg;
    logic [$clog2(LATENCY+2):0] cnt_reg;
    fvn_link_t link [OCTAVES+1];
    fvn_link_t link0_reg;
    logic signed [32:0] cx_prod, cy_prod;
    logic signed [17:0] sat;
    logic signed [40:0] lhs, rhs;
    logic acc_in, acc_out;
    logic [18:0] q_mem [QD];
    logic [QW-1:0] wp_reg, rp_reg;
    logic [QW:0] qc_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0; scale_reg <= 16'd20972;
            density_reg <= 17'd26214; eased_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SEED:        seed_reg <= cfg_data;
                REG_NOISE_SCALE: scale_reg <= cfg_data[15:0];
                REG_DENSITY:     density_reg <= cfg_data[16:0];
                REG_EASED_MODE:  eased_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Credit count of words in flight plus the queued words.
    assign acc_in  = s_tvalid && s_tready;
    assign acc_out = m_tvalid && m_tready;
    assign s_tready = cnt_reg < ($bits(cnt_reg))'(LATENCY + 1);
    always_ff @(posedge aclk) begin
        if (!aresetn) cnt_reg <= '0;
        else cnt_reg <= cnt_reg + ($bits(cnt_reg))'(acc_in) - ($bits(cnt_reg))'(acc_out);
    end

    // Scale the cell into Q16 noise coordinates.
    assign cx_prod = $signed(s_tdata[15:0]) * $signed({1'b0, scale_reg});
    assign cy_prod = $signed(s_tdata[31:16]) * $signed({1'b0, scale_reg});
    always_ff @(posedge aclk) begin
        if (!aresetn) link0_reg.vld <= 1'b0;
        else link0_reg.vld <= acc_in;
        link0_reg.cx  <= 41'(cx_prod);
        link0_reg.cy  <= 41'(cy_prod);
        link0_reg.sum <= '0;
    end
    assign link[0] = link0_reg;

    for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
        fvn_octave_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .octave(3'(k)), .seed(seed_reg),
            .eased(eased_reg), .link_in(link[k]), .link_out(link[k+1])
        );
    end

    // Saturate and compare, then a small result queue of depth QD.
    assign sat = (link[OCTAVES].sum > 20'sd131071) ? 18'sd131071
               : (link[OCTAVES].sum < -20'sd131072) ? -18'sd131072
               : link[OCTAVES].sum[17:0];
    assign lhs = 41'(sat) <<< (OCTAVES - 1);
    assign rhs = 41'sd2 * ($signed({24'd0, density_reg}) - 41'sd32768)
               * 41'((1 << OCTAVES) - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; qc_reg <= '0;
        end else begin
            if (link[OCTAVES].vld)
                wp_reg <= (wp_reg == QW'(QD - 1)) ? '0 : wp_reg + QW'(1);
            if (acc_out)
                rp_reg <= (rp_reg == QW'(QD - 1)) ? '0 : rp_reg + QW'(1);
            qc_reg <= qc_reg + (QW+1)'(link[OCTAVES].vld) - (QW+1)'(acc_out);
        end
        if (link[OCTAVES].vld) q_mem[wp_reg] <= {sat, lhs < rhs};
    end
    assign m_tvalid = qc_reg != '0;
    assign m_tdata  = {5'd0, q_mem[rp_reg]};

    `FVN_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= LATENCY + 1)
    `FVN_ASSERT_NEXT(a_in_pipe, aclk, aresetn, acc_in, link[0].vld)
    `FVN_ASSERT_IMP(a_out_has, aclk, aresetn, m_tvalid, cnt_reg != '0)

endmodule
